FILE: sv/imma_pkg.sv
// ----------------------------------------------------------------------------
// imma_pkg: shared types and constants
// Beat layouts, tile types and sizing constants for the int8 tile MAC unit.
// ----------------------------------------------------------------------------
package imma_pkg;

   localparam int DIM_MAX     = 4;   // largest tile edge
   localparam int DATA_W      = 8;
   localparam int PROD_W      = 16;
   localparam int ACC_W       = 32;
   localparam int IDX_W       = 2;   // out_row / out_col width
   localparam int QUEUE_DEPTH = 4;   // power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one k-step
   typedef struct packed {
      logic signed [DATA_W-1:0] a_row0;
      logic signed [DATA_W-1:0] a_row1;
      logic signed [DATA_W-1:0] a_row2;
      logic signed [DATA_W-1:0] a_row3;
      logic signed [DATA_W-1:0] b_col0;
      logic signed [DATA_W-1:0] b_col1;
      logic signed [DATA_W-1:0] b_col2;
      logic signed [DATA_W-1:0] b_col3;
      logic                     first_step;
      logic                     last_step;
   } req_type;

   // one tile sum
   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [ACC_W-1:0] sum_value;
      logic                    last_result;
   } rsp_type;

   typedef logic [DIM_MAX-1:0][DIM_MAX-1:0][ACC_W-1:0] tile_type;

   // front -> back
   typedef struct packed {
      logic    valid;
      logic    is_last;  // step closes the tile
      req_type beat;
   } step_type;

   // back -> drain
   typedef struct packed {
      logic     load;
      tile_type tile;
   } snap_type;

   function automatic int clamp_dim(input int d);
      return (d > DIM_MAX) ? DIM_MAX : d;
   endfunction

endpackage

FILE: sv/imma_front.sv
// ----------------------------------------------------------------------------
// imma_front: input queue
// Takes k-step beats, tags closing steps and buffers them for the MAC back end.
// ----------------------------------------------------------------------------
module imma_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  imma_pkg::req_type req_data,
   output imma_pkg::step_type step,
   input  logic             step_pull
);
   import imma_pkg::*;

   req_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = step_pull && (count_ff != '0);

   assign step.valid   = (count_ff != '0);
   assign step.beat    = mem_ff[rd_ptr_ff];
   assign step.is_last = mem_ff[rd_ptr_ff].last_step;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

FILE: sv/imma_mac.sv
// ----------------------------------------------------------------------------
// imma_mac: outer-product accumulate array
// Product stage of 16 8x8 multipliers, then 16 32-bit accumulators.
// ----------------------------------------------------------------------------
module imma_mac #(
   parameter int TILE_ROWS = imma_pkg::DIM_MAX,
   parameter int TILE_COLS = imma_pkg::DIM_MAX
) (
   input  logic               clock,
   input  logic               reset,
   input  imma_pkg::step_type step,
   output logic               step_pull,
   input  logic               drain_ready,
   output imma_pkg::snap_type snap
);
   import imma_pkg::*;

   localparam int R_ACT = clamp_dim(TILE_ROWS);
   localparam int C_ACT = clamp_dim(TILE_COLS);

   logic signed [DATA_W-1:0] a_v [DIM_MAX];
   logic signed [DATA_W-1:0] b_v [DIM_MAX];

   logic signed [PROD_W-1:0] prod_ff [DIM_MAX][DIM_MAX];
   logic                     p_valid_ff;
   logic                     p_first_ff;
   logic                     p_last_ff;
   logic                     p_advance;

   logic [ACC_W-1:0] acc_ff [DIM_MAX][DIM_MAX];
   logic [ACC_W-1:0] acc_in [DIM_MAX][DIM_MAX];

   assign a_v[0] = step.beat.a_row0;
   assign a_v[1] = step.beat.a_row1;
   assign a_v[2] = step.beat.a_row2;
   assign a_v[3] = step.beat.a_row3;
   assign b_v[0] = step.beat.b_col0;
   assign b_v[1] = step.beat.b_col1;
   assign b_v[2] = step.beat.b_col2;
   assign b_v[3] = step.beat.b_col3;

   // a closing step waits in the product stage until the drain bank is free
   assign p_advance = p_valid_ff && (!p_last_ff || drain_ready);
   assign step_pull = !p_valid_ff || p_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (step_pull) begin
         p_valid_ff <= step.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step_pull) begin
         p_first_ff <= step.beat.first_step;
         p_last_ff  <= step.is_last;
      end
   end

   genvar gi, gj;
   generate
      for (gi = 0; gi < DIM_MAX; gi++) begin : g_row
         for (gj = 0; gj < DIM_MAX; gj++) begin : g_col
            if (gi < R_ACT && gj < C_ACT) begin : g_act
               always_ff @(posedge clock) begin
                  if (step_pull) begin
                     prod_ff[gi][gj] <= a_v[gi] * b_v[gj];
                  end
               end
               always_comb begin
                  if (p_first_ff) begin
                     acc_in[gi][gj] = ACC_W'(prod_ff[gi][gj]);
                  end else begin
                     acc_in[gi][gj] = acc_ff[gi][gj] + ACC_W'(prod_ff[gi][gj]);
                  end
               end
            end else begin : g_idle
               // outside the active tile: never emitted
               assign prod_ff[gi][gj] = '0;
               assign acc_in[gi][gj]  = '0;
            end

            always_ff @(posedge clock) begin
               if (reset) begin
                  acc_ff[gi][gj] <= '0;
               end else if (p_advance) begin
                  acc_ff[gi][gj] <= acc_in[gi][gj];
               end
            end

            assign snap.tile[gi][gj] = acc_in[gi][gj];
         end
      end
   endgenerate

   assign snap.load = p_advance && p_last_ff;

endmodule

FILE: sv/imma_drain.sv
// ----------------------------------------------------------------------------
// imma_drain: result serializer
// Holds a snapshot of the finished tile and sends it out row-major.
// ----------------------------------------------------------------------------
module imma_drain #(
   parameter int TILE_ROWS = imma_pkg::DIM_MAX,
   parameter int TILE_COLS = imma_pkg::DIM_MAX
) (
   input  logic               clock,
   input  logic               reset,
   input  imma_pkg::snap_type snap,
   output logic               drain_ready,
   output logic               drain_busy,
   output logic               empty,
   input  logic               pop,
   output imma_pkg::rsp_type  rsp_data
);
   import imma_pkg::*;

   localparam int R_ACT = clamp_dim(TILE_ROWS);
   localparam int C_ACT = clamp_dim(TILE_COLS);
   localparam logic [IDX_W-1:0] ROW_END = IDX_W'(R_ACT - 1);
   localparam logic [IDX_W-1:0] COL_END = IDX_W'(C_ACT - 1);

   tile_type         bank_ff;
   logic             busy_ff;
   logic [IDX_W-1:0] row_ff, col_ff;
   rsp_type          out_ff;
   logic             out_valid_ff;
   logic             at_end, move;

   assign at_end      = (row_ff == ROW_END) && (col_ff == COL_END);
   assign move        = busy_ff && (!out_valid_ff || pop);
   assign drain_ready = !busy_ff || (move && at_end);
   assign drain_busy  = busy_ff;
   assign empty       = !out_valid_ff;
   assign rsp_data    = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (snap.load) begin
            busy_ff <= 1'b1;
            row_ff  <= '0;
            col_ff  <= '0;
         end else if (move) begin
            if (at_end) begin
               busy_ff <= 1'b0;
            end else if (col_ff == COL_END) begin
               col_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end

         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap.load) begin
         bank_ff <= snap.tile;
      end
      if (move) begin
         out_ff.out_row     <= row_ff;
         out_ff.out_col     <= col_ff;
         out_ff.sum_value   <= bank_ff[row_ff][col_ff];
         out_ff.last_result <= at_end;
      end
   end

endmodule

FILE: sv/int8_tile_matmul_accumulate_unit.sv
// ----------------------------------------------------------------------------
// int8_tile_matmul_accumulate_unit: int8 GEMM tile engine, int32 accumulate
// Adds the outer product of an A column slice and a B row slice into a 4x4
// tile of wrapping 32-bit sums per k-step; a closing step emits the tile.
// ----------------------------------------------------------------------------
//
//  channel | ports                      | beat
//  --------+----------------------------+----------------------------------
//  request | push, full, req_data       | one k-step (4 A, 4 B, first/last)
//  result  | empty, pop, rsp_data       | one tile sum with row/col, last
//
// Flow: one k-step per clock unless a closing step waits for the drain bank.
//   A step passes the queue, the product registers and the accumulators; a
//   closing step's tile goes on through the drain bank to rsp_data.
// Emission: TILE_ROWS*TILE_COLS beats, one per clock while pop keeps up,
//   set by the single drain bank read port. Tiles accumulate as one drains;
//   a second closing step waits in the product stage until the bank frees up.
// Reset: synchronous; clears the accumulators, queue and drain control.
// Stalls: full rises only when the 4-deep input queue backs up behind a
//   waiting closing step; a held-off pop never blocks new steps otherwise.
// ----------------------------------------------------------------------------
module int8_tile_matmul_accumulate_unit #(
   parameter int TILE_ROWS = imma_pkg::DIM_MAX,
   parameter int TILE_COLS = imma_pkg::DIM_MAX
) (
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              push,
   output logic              full,
   input  imma_pkg::req_type req_data,
   // result side
   output logic              empty,
   input  logic              pop,
   output imma_pkg::rsp_type rsp_data
);
   import imma_pkg::*;

   localparam int R_ACT = clamp_dim(TILE_ROWS);
   localparam int C_ACT = clamp_dim(TILE_COLS);

   step_type step;
   logic     step_pull;
   snap_type snap;
   logic     drain_ready;
   logic     drain_busy;

   // front: queue between the request port and the MAC array
   imma_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .step      (step),
      .step_pull (step_pull)
   );

   // back: multiply, accumulate, hand off finished tiles
   imma_mac #(
      .TILE_ROWS (TILE_ROWS),
      .TILE_COLS (TILE_COLS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .step_pull   (step_pull),
      .drain_ready (drain_ready),
      .snap        (snap)
   );

   // drain: snapshot bank and output register
   imma_drain #(
      .TILE_ROWS (TILE_ROWS),
      .TILE_COLS (TILE_COLS)
   ) u_drain (
      .clock       (clock),
      .reset       (reset),
      .snap        (snap),
      .drain_ready (drain_ready),
      .drain_busy  (drain_busy),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // the marked beat is always the bottom-right corner of the active tile
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last_result) |->
         (rsp_data.out_row == IDX_W'(R_ACT - 1)) &&
         (rsp_data.out_col == IDX_W'(C_ACT - 1)))
      else $error("last_result on a beat that is not the tile corner");

   // after a taken step the back end sees a valid step on the next clock
   a_step_queued: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> step.valid)
      else $error("accepted step missing from the queue");

   // a snapshot load always starts a drain
   a_snap_drains: assert property (@(posedge clock) disable iff (reset)
      snap.load |=> drain_busy)
      else $error("tile snapshot taken but drain not started");

   // with the output register free, a fresh load shows the tile origin first
   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      snap.load && !drain_busy && empty |=> ##1 (!empty && rsp_data.out_row == '0 &&
         rsp_data.out_col == '0))
      else $error("drain did not start at the tile origin");

endmodule

FILE: verif/imma_tile_checker.sv
// ----------------------------------------------------------------------------
// imma_tile_checker: tile sum predictor and result compare
// Watches the k-step and tile-sum channels of the int8 tile MAC unit, keeps
// its own 4x4 wrapping accumulators, and checks every tile sum in order.
// ----------------------------------------------------------------------------
module imma_tile_checker
   import imma_pkg::*;
#(
   parameter int TILE_ROWS = DIM_MAX,
   parameter int TILE_COLS = DIM_MAX
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_data,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      sums_due,
   output int      steps_taken,
   output int      sums_checked
);

   localparam int ROWS_ACT   = (TILE_ROWS > DIM_MAX) ? DIM_MAX : TILE_ROWS;
   localparam int COLS_ACT   = (TILE_COLS > DIM_MAX) ? DIM_MAX : TILE_COLS;
   localparam int REPORT_MAX = 10;

   logic [ACC_W-1:0] tile_acc [DIM_MAX][DIM_MAX];
   rsp_type          tile_sums_due [$];

   function automatic void clear_tile();
      for (int i = 0; i < DIM_MAX; i++)
         for (int j = 0; j < DIM_MAX; j++)
            tile_acc[i][j] = '0;
   endfunction

   function automatic void note_mismatch(input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("checker: tile sum mismatch: expected row %0d col %0d sum %0d last %0b,",
                  want.out_row, want.out_col, want.sum_value, want.last_result,
                  " got row %0d col %0d sum %0d last %0b",
                  got.out_row, got.out_col, got.sum_value, got.last_result);
   endfunction

   // one k-step: optional clear, outer product add, optional tile emit
   function automatic void accumulate_step(input req_type step);
      int      a_slice [DIM_MAX];
      int      b_slice [DIM_MAX];
      int      prod;
      rsp_type sum_beat;
      a_slice[0] = int'(step.a_row0);
      a_slice[1] = int'(step.a_row1);
      a_slice[2] = int'(step.a_row2);
      a_slice[3] = int'(step.a_row3);
      b_slice[0] = int'(step.b_col0);
      b_slice[1] = int'(step.b_col1);
      b_slice[2] = int'(step.b_col2);
      b_slice[3] = int'(step.b_col3);
      if (step.first_step)
         clear_tile();
      for (int i = 0; i < ROWS_ACT; i++)
         for (int j = 0; j < COLS_ACT; j++) begin
            prod = a_slice[i] * b_slice[j];
            tile_acc[i][j] = tile_acc[i][j] + ACC_W'(prod);  // wraps mod 2^32
         end
      if (step.last_step)
         for (int i = 0; i < ROWS_ACT; i++)
            for (int j = 0; j < COLS_ACT; j++) begin
               sum_beat.out_row     = IDX_W'(i);
               sum_beat.out_col     = IDX_W'(j);
               sum_beat.sum_value   = tile_acc[i][j];
               sum_beat.last_result = (i == ROWS_ACT - 1) && (j == COLS_ACT - 1);
               tile_sums_due.push_back(sum_beat);
            end
   endfunction

   // Values read here are the pre-edge ones; inputs move on the falling edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_tile();
         tile_sums_due.delete();
         mismatches   = 0;
         steps_taken  = 0;
         sums_checked = 0;
      end else begin
         if (pop && !empty) begin
            if (tile_sums_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("checker: unexpected tile sum row %0d col %0d sum %0d last %0b",
                           rsp_data.out_row, rsp_data.out_col, rsp_data.sum_value,
                           rsp_data.last_result);
            end else begin
               want = tile_sums_due.pop_front();
               sums_checked++;
               if (rsp_data.out_row !== want.out_row || rsp_data.out_col !== want.out_col ||
                   rsp_data.sum_value !== want.sum_value ||
                   rsp_data.last_result !== want.last_result)
                  note_mismatch(want, rsp_data);
            end
         end
         if (push && !full) begin
            steps_taken++;
            accumulate_step(req_data);
         end
      end
      sums_due = tile_sums_due.size();
   end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: int8 tile MAC unit test
// Drives k-steps into the unit and pops tile sums under random back-pressure;
// a checker beside the unit predicts and compares every sum.
// ----------------------------------------------------------------------------
module testbench;
   import imma_pkg::*;

   localparam int TILE_ROWS   = DIM_MAX;
   localparam int TILE_COLS   = DIM_MAX;
   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 32;      // pipeline plus a full 16-beat drain
   localparam int CYCLE_LIMIT = 40000;    // ~110 steps

   logic    clock = 1'b0;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   int mismatches;
   int sums_due;
   int steps_taken;
   int sums_checked;
   int cycle_count = 0;

   // percent of cycles in which each side holds off
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;

   always #5 clock = ~clock;

   int8_tile_matmul_accumulate_unit #(
      .TILE_ROWS (TILE_ROWS),
      .TILE_COLS (TILE_COLS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   imma_tile_checker #(
      .TILE_ROWS (TILE_ROWS),
      .TILE_COLS (TILE_COLS)
   ) tile_check (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .sums_due     (sums_due),
      .steps_taken  (steps_taken),
      .sums_checked (sums_checked)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tile sums still due", cycle_count, sums_due);
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: one pop decision per falling edge
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Extremes come up often; the rest is any 8-bit pattern.
   function automatic logic signed [DATA_W-1:0] pick_operand();
      case ($urandom_range(7))
         0:       return -8'sd128;
         1:       return 8'sd127;
         2:       return 8'sd0;
         3:       return -8'sd1;
         default: return DATA_W'($urandom());
      endcase
   endfunction

   function automatic req_type random_step(input logic first, input logic last);
      req_type step;
      step.a_row0     = pick_operand();
      step.a_row1     = pick_operand();
      step.a_row2     = pick_operand();
      step.a_row3     = pick_operand();
      step.b_col0     = pick_operand();
      step.b_col1     = pick_operand();
      step.b_col2     = pick_operand();
      step.b_col3     = pick_operand();
      step.first_step = first;
      step.last_step  = last;
      return step;
   endfunction

   function automatic req_type fixed_step(input logic signed [DATA_W-1:0] a0, a1, a2, a3,
                                          input logic signed [DATA_W-1:0] b0, b1, b2, b3,
                                          input logic first, input logic last);
      return '{a_row0: a0, a_row1: a1, a_row2: a2, a_row3: a3,
               b_col0: b0, b_col1: b1, b_col2: b2, b_col3: b3,
               first_step: first, last_step: last};
   endfunction

   // One beat: optional idle cycles, then hold push until the unit takes it.
   // push is only ever written at a falling edge, once per edge.
   task automatic send_step(input req_type step);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= step;
      do @(posedge clock); while (full);
   endtask

   // drop push and hold off until every predicted sum has been popped
   task automatic wait_all_sums();
      @(negedge clock);
      push <= 1'b0;
      while (sums_due != 0)
         @(negedge clock);
   endtask

   task automatic directed_steps();
      // no first flag straight after reset: adds onto the zeroed accumulators
      send_step(fixed_step(127, 127, 127, 127, 127, 127, 127, 127, 1'b0, 1'b0));
      // closing step without a first flag
      send_step(fixed_step(-128, -128, -128, -128, 127, 127, 127, 127, 1'b0, 1'b1));
      // kept sums: a new tile without first continues from the emitted one
      send_step(fixed_step(1, -1, 2, -2, 3, -3, 4, -4, 1'b0, 1'b1));
      // first and last on the same step
      send_step(fixed_step(-128, 127, 0, -1, -1, 0, 127, -128, 1'b1, 1'b1));
      // three-step tile at the largest product magnitude
      send_step(fixed_step(-128, -128, -128, -128, -128, -128, -128, -128, 1'b1, 1'b0));
      send_step(fixed_step(-128, -128, -128, -128, -128, -128, -128, -128, 1'b0, 1'b0));
      send_step(fixed_step(-128, -128, -128, -128, -128, -128, -128, -128, 1'b0, 1'b1));
      // mixed signs at the extremes
      send_step(fixed_step(127, -128, 127, -128, -128, 127, -128, 127, 1'b1, 1'b0));
      send_step(fixed_step(-128, 127, -128, 127, -128, 127, -128, 127, 1'b0, 1'b1));
      // all zero
      send_step(fixed_step(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
      // alternating bit patterns on every lane
      send_step(fixed_step(8'sh55, 8'shAA, 8'sh55, 8'shAA, 8'shAA, 8'sh55, 8'shAA, 8'sh55,
                           1'b1, 1'b0));
      send_step(fixed_step(8'shAA, 8'sh55, 8'shAA, 8'sh55, 8'sh55, 8'shAA, 8'sh55, 8'shAA,
                           1'b0, 1'b1));
      // first flag on a step that does not close: clears mid-stream
      send_step(fixed_step(5, 6, 7, 8, -9, -10, -11, -12, 1'b0, 1'b0));
      send_step(fixed_step(1, 1, 1, 1, 1, 1, 1, 1, 1'b1, 1'b0));
      send_step(fixed_step(-1, -1, -1, -1, 1, 1, 1, 1, 1'b0, 1'b1));
   endtask

   // Mostly well-formed tiles (first ... last) with random operands; some
   // tiles skip first and build on kept sums, a few beats carry random flags.
   task automatic random_tiles(input int n_steps);
      int made;
      int mode;
      int k_len;
      made = 0;
      while (made < n_steps) begin
         mode = $urandom_range(9);
         if (mode <= 6) begin
            k_len = $urandom_range(1, 6);
            for (int s = 0; s < k_len; s++)
               send_step(random_step((s == 0) && (mode != 6), s == k_len - 1));
            made += k_len;
         end else begin
            send_step(random_step(1'($urandom_range(1)), 1'($urandom_range(1))));
            made++;
         end
      end
   endtask

   initial begin
      reset    = 1'b1;
      push     = 1'b0;
      req_data = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase 1: sender idles lightly, receiver stalls hard
      send_idle_pct = 35;
      rcv_idle_pct  = 58;
      directed_steps();
      wait_all_sums();          // sender holds off until the unit has drained
      random_tiles(31);

      // phase 2: roles swapped
      send_idle_pct = 58;
      rcv_idle_pct  = 35;
      random_tiles(31);

      // phase 3: back to back
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      random_tiles(31);

      wait_all_sums();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d k-steps and %0d tile sums: corner operands, kept and cleared tiles,",
               steps_taken, sums_checked);
      $display("random tiles under three stall mixes and a full drain hold-off");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
sv/imma_pkg.sv
sv/imma_front.sv
sv/imma_mac.sv
sv/imma_drain.sv
sv/int8_tile_matmul_accumulate_unit.sv
verif/imma_tile_checker.sv
verif/testbench.sv
